>>> rtl/core/pahc_pkg.sv
package pahc_pkg;

	// Sizes of the store and of the item fields
	localparam int MAX_SLOTS = 256;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int ID_W      = 16;
	localparam int KEY_W     = 32;
	localparam int FRAME_W   = 32;
	localparam int TYPE_W    = 4;
	localparam int CSIZE_W   = 9;
	localparam int OUTC_W    = 2;

	// Remainder unit: key bits consumed per cycle
	localparam int DIV_BITS  = 8;
	localparam int DIV_STEPS = KEY_W / DIV_BITS;
	localparam int DSTEP_W   = $clog2(DIV_STEPS);

	// Register port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_TABLE_SIZE = '0;
	localparam logic [CSIZE_W-1:0]   CSIZE_RESET    = CSIZE_W'(1);

	// Operation codes
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INVAL  = 1'b1;

	// Outcome codes
	localparam logic [OUTC_W-1:0] OUT_HIT   = 2'd0;
	localparam logic [OUTC_W-1:0] OUT_CLAIM = 2'd1;
	localparam logic [OUTC_W-1:0] OUT_SPARE = 2'd2;
	localparam logic [OUTC_W-1:0] OUT_INVAL = 2'd3;

	// One slot of the store
	typedef struct packed {
		logic [ID_W-1:0]    first;
		logic [ID_W-1:0]    second;
		logic [FRAME_W-1:0] frame;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic rd;
		logic upd;
		logic scan_rd;
		logic out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/core/pahc_req_if.sv
interface pahc_req_if;
	import pahc_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [ID_W-1:0]   object_a_id;
	logic [ID_W-1:0]   object_b_id;
	logic [KEY_W-1:0]  shape_key_a;
	logic [KEY_W-1:0]  shape_key_b;
	logic [TYPE_W-1:0] shape_type_a;
	logic [TYPE_W-1:0] shape_type_b;
	logic [FRAME_W-1:0] sim_frame;

	modport source (
		output valid, operation, object_a_id, object_b_id, shape_key_a, shape_key_b,
		       shape_type_a, shape_type_b, sim_frame,
		input  ready
	);

	modport sink (
		input  valid, operation, object_a_id, object_b_id, shape_key_a, shape_key_b,
		       shape_type_a, shape_type_b, sim_frame,
		output ready
	);

endinterface

>>> rtl/core/pahc_rsp_if.sv
interface pahc_rsp_if;
	import pahc_pkg::*;

	logic              valid;
	logic              ready;
	logic [OUTC_W-1:0] outcome;
	logic [SLOT_W-1:0] slot_index;
	logic [ID_W-1:0]   ordered_first;
	logic [ID_W-1:0]   ordered_second;

	modport source (
		output valid, outcome, slot_index, ordered_first, ordered_second,
		input  ready
	);

	modport sink (
		input  valid, outcome, slot_index, ordered_first, ordered_second,
		output ready
	);

endinterface

>>> rtl/core/pahc_ram.sv
module pahc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/pahc_ctrl.sv
module pahc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_operation,
	output logic          in_ready,
	input  pahc_pkg::sts_t sts,
	output pahc_pkg::cmd_t cmd
);
	import pahc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_READ,
		S_UPD,
		S_SCAN,
		S_FLUSH,
		S_DONE
	} state_t;

	state_t             state_q;
	logic               rdy_q;
	logic [DSTEP_W-1:0] step_q;

	assign in_ready = rdy_q;

	// Commands decoded from the current state
	always_comb begin
		cmd          = '0;
		cmd.load     = rdy_q && in_valid;
		cmd.div_step = (state_q == S_DIV);
		cmd.rd       = (state_q == S_READ);
		cmd.upd      = (state_q == S_UPD);
		cmd.scan_rd  = (state_q == S_SCAN);
		cmd.out_load = (state_q == S_DONE) && sts.out_free;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rdy_q   <= 1'b1;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (rdy_q && in_valid) begin
						rdy_q   <= 1'b0;
						step_q  <= '0;
						state_q <= (in_operation == OP_INVAL) ? S_SCAN : S_DIV;
					end
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == DSTEP_W'(DIV_STEPS - 1)) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (sts.scan_last) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (sts.out_free) begin
						rdy_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					rdy_q   <= 1'b1;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/pahc_dpath.sv
module pahc_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pahc_pkg::cmd_t                  cmd,
	output pahc_pkg::sts_t                  sts,
	input  logic [pahc_pkg::CSIZE_W-1:0]    n_act,
	input  logic                            clr,
	input  logic                            in_operation,
	input  logic [pahc_pkg::ID_W-1:0]       in_object_a_id,
	input  logic [pahc_pkg::ID_W-1:0]       in_object_b_id,
	input  logic [pahc_pkg::KEY_W-1:0]      in_shape_key_a,
	input  logic [pahc_pkg::KEY_W-1:0]      in_shape_key_b,
	input  logic [pahc_pkg::TYPE_W-1:0]     in_shape_type_a,
	input  logic [pahc_pkg::TYPE_W-1:0]     in_shape_type_b,
	input  logic [pahc_pkg::FRAME_W-1:0]    in_sim_frame,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pahc_pkg::OUTC_W-1:0]     out_outcome,
	output logic [pahc_pkg::SLOT_W-1:0]     out_slot_index,
	output logic [pahc_pkg::ID_W-1:0]       out_ordered_first,
	output logic [pahc_pkg::ID_W-1:0]       out_ordered_second
);
	import pahc_pkg::*;

	logic                 inval_q;
	logic [ID_W-1:0]      first_q;
	logic [ID_W-1:0]      second_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [KEY_W-1:0]     x_q;
	logic [SLOT_W-1:0]    rem_q;
	logic [SLOT_W-1:0]    idx_q;
	logic [SLOT_W-1:0]    addr_s1;
	logic                 pend_s1;
	logic                 vld_s2;
	logic [OUTC_W-1:0]    outc_q;
	logic                 out_valid_q;
	logic [MAX_SLOTS-1:0] valid_q;

	logic                 a_first;
	logic [KEY_W-1:0]     x_nx;
	logic [SLOT_W-1:0]    rem_nx;
	logic                 re;
	logic [SLOT_W-1:0]    raddr;
	logic [ENTRY_W-1:0]   rdata;
	logic                 we;
	logic [SLOT_W-1:0]    waddr;
	entry_t               wdata;
	entry_t               ent;
	logic                 hit;
	logic                 stale;
	logic [FRAME_W-1:0]   age;

	// Ordering by shape type; an invalidate keeps object a in first place
	assign a_first = (in_shape_type_a <= in_shape_type_b) || (in_operation == OP_INVAL);

	// Remainder unit: eight restoring steps per cycle, key MSB first
	always_comb begin
		logic [KEY_W-1:0]   xs;
		logic [SLOT_W-1:0]  r;
		logic [CSIZE_W-1:0] t;
		xs = x_q;
		r  = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			t  = {r, xs[KEY_W-1]};
			xs = {xs[KEY_W-2:0], 1'b0};
			if (t >= n_act) begin
				t = t - n_act;
			end
			r = t[SLOT_W-1:0];
		end
		x_nx   = xs;
		rem_nx = r;
	end

	// Store access
	assign re    = cmd.rd || cmd.scan_rd;
	assign raddr = cmd.rd ? rem_q : idx_q;

	pahc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Slots never written since the last clear read as empty
	assign ent   = vld_s2 ? entry_t'(rdata) : '0;
	assign hit   = (ent.first == first_q) && (ent.second == second_q);
	assign age   = frame_q - ent.frame;
	assign stale = (age > FRAME_W'(1));

	// Write-back: lookup refresh or claim, else invalidate scan
	always_comb begin
		we    = 1'b0;
		waddr = rem_q;
		wdata = '{first: first_q, second: second_q, frame: frame_q};
		if (cmd.upd) begin
			we = hit || stale;
		end else if (pend_s1) begin
			we           = 1'b1;
			waddr        = addr_s1;
			wdata.first  = (ent.first == first_q) ? '0 : ent.first;
			wdata.second = (ent.second == first_q) ? '0 : ent.second;
			wdata.frame  = ent.frame;
		end
	end

	assign sts.scan_last = ({1'b0, idx_q} == (n_act - CSIZE_W'(1)));
	assign sts.out_free  = !out_valid_q || out_ready;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			pend_s1 <= cmd.scan_rd;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item registers and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			inval_q  <= in_operation;
			first_q  <= a_first ? in_object_a_id : in_object_b_id;
			second_q <= a_first ? in_object_b_id : in_object_a_id;
			frame_q  <= in_sim_frame;
			x_q      <= in_shape_key_a ^ in_shape_key_b;
			rem_q    <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.div_step) begin
				x_q   <= x_nx;
				rem_q <= rem_nx;
			end
			if (cmd.scan_rd) begin
				idx_q <= idx_q + 1'b1;
			end
		end
		if (re) begin
			vld_s2 <= valid_q[raddr];
		end
		addr_s1 <= idx_q;
		if (cmd.upd) begin
			outc_q <= hit ? OUT_HIT : (stale ? OUT_CLAIM : OUT_SPARE);
		end
		if (cmd.out_load) begin
			if (inval_q == OP_INVAL) begin
				out_outcome        <= OUT_INVAL;
				out_slot_index     <= '0;
				out_ordered_first  <= '0;
				out_ordered_second <= '0;
			end else begin
				out_outcome        <= outc_q;
				out_slot_index     <= rem_q;
				out_ordered_first  <= first_q;
				out_ordered_second <= second_q;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/pair_agent_hash_cache.sv
// Channel  Dir  Carries
// -------  ---  -------------------------------------------------------------
// req      in   operation, object ids, shape keys, shape types, frame number
// rsp      out  outcome, slot index, ordered first and second object id
// APB      in   table size register at byte address 0
//
// Lookup: the remainder unit reduces the key 8 bits a cycle, then come one store
// read and one update; a new request is taken only once the result is loaded for rsp.
// Invalidate: a sweep over the slots in use, one slot a cycle, through the single
// read and write port of the slot memory.
// Reset and table size writes empty the store at once through per-slot valid
// flags; there is no clearing pass. A result waiting on rsp holds the block
// in its final cycle only once the next result is ready.
module pair_agent_hash_cache (
	input  logic                          clk,
	input  logic                          arst_n,
	pahc_req_if.sink                      req,
	pahc_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pahc_pkg::PADDR_W-1:0]  paddr,
	input  logic [pahc_pkg::PDATA_W-1:0]  pwdata,
	output logic [pahc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import pahc_pkg::*;

	logic [CSIZE_W-1:0]   csize_q;
	logic [CSIZE_W-1:0]   n_act;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 csize_wr;
	cmd_t                 cmd;
	sts_t                 sts;

	// Register port
	assign pready   = 1'b1;
	assign reg_idx  = paddr[PADDR_W-1:2];
	assign csize_wr = psel && penable && pwrite && (reg_idx == REG_TABLE_SIZE);
	assign prdata   = (reg_idx == REG_TABLE_SIZE) ? PDATA_W'(csize_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csize_q <= CSIZE_RESET;
		end else if (csize_wr) begin
			csize_q <= pwdata[CSIZE_W-1:0];
		end
	end

	// Slots in use: zero reads as one, saturate at the store depth
	always_comb begin
		if (csize_q == '0) begin
			n_act = CSIZE_W'(1);
		end else if (csize_q > CSIZE_W'(MAX_SLOTS)) begin
			n_act = CSIZE_W'(MAX_SLOTS);
		end else begin
			n_act = csize_q;
		end
	end

	pahc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_operation(req.operation),
		.in_ready    (req.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	pahc_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.n_act             (n_act),
		.clr               (csize_wr),
		.in_operation      (req.operation),
		.in_object_a_id    (req.object_a_id),
		.in_object_b_id    (req.object_b_id),
		.in_shape_key_a    (req.shape_key_a),
		.in_shape_key_b    (req.shape_key_b),
		.in_shape_type_a   (req.shape_type_a),
		.in_shape_type_b   (req.shape_type_b),
		.in_sim_frame      (req.sim_frame),
		.out_valid         (rsp.valid),
		.out_ready         (rsp.ready),
		.out_outcome       (rsp.outcome),
		.out_slot_index    (rsp.slot_index),
		.out_ordered_first (rsp.ordered_first),
		.out_ordered_second(rsp.ordered_second)
	);

endmodule

>>> rtl/core/pahc_checker.sv
module pahc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic                        req_ready,
	input  logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  logic [pahc_pkg::OUTC_W-1:0] rsp_outcome,
	input  logic [pahc_pkg::SLOT_W-1:0] rsp_slot_index,
	input  logic [pahc_pkg::ID_W-1:0]   rsp_ordered_first,
	input  logic [pahc_pkg::ID_W-1:0]   rsp_ordered_second
);
	import pahc_pkg::*;

	// One request at a time: an accepted request closes the input
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	// A pending result stays until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before being taken");

	// Invalidate results carry no slot and no ids
	a_inval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_outcome == OUT_INVAL) |->
			(rsp_slot_index == '0) && (rsp_ordered_first == '0) &&
			(rsp_ordered_second == '0))
		else $error("invalidate result with nonzero fields");

	// A new result only appears at the end of a busy period
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("result raised without work in progress");

endmodule

bind pair_agent_hash_cache pahc_checker u_pahc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_outcome       (rsp.outcome),
	.rsp_slot_index    (rsp.slot_index),
	.rsp_ordered_first (rsp.ordered_first),
	.rsp_ordered_second(rsp.ordered_second)
);

>>> sim/pair_agent_hash_cache_tb.sv
`timescale 1ns / 100ps

module pair_agent_hash_cache_tb;
	import pahc_pkg::*;

	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int POOL_N       = 8;
	localparam int PRINT_CAP    = 40;

	// One lookup or invalidate request as the driver holds it
	typedef struct packed {
		logic               operation;
		logic [ID_W-1:0]    a_id;
		logic [ID_W-1:0]    b_id;
		logic [KEY_W-1:0]   key_a;
		logic [KEY_W-1:0]   key_b;
		logic [TYPE_W-1:0]  type_a;
		logic [TYPE_W-1:0]  type_b;
		logic [FRAME_W-1:0] frame;
	} pair_req_t;

	// One result as the block returns it
	typedef struct packed {
		logic [OUTC_W-1:0] outcome;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   first;
		logic [ID_W-1:0]   second;
	} pair_rsp_t;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	pair_req_t drv_item   = '0;
	logic      drv_valid  = 1'b0;
	logic      sink_ready = 1'b0;

	pahc_req_if req ();
	pahc_rsp_if rsp ();

	assign req.valid        = drv_valid;
	assign req.operation    = drv_item.operation;
	assign req.object_a_id  = drv_item.a_id;
	assign req.object_b_id  = drv_item.b_id;
	assign req.shape_key_a  = drv_item.key_a;
	assign req.shape_key_b  = drv_item.key_b;
	assign req.shape_type_a = drv_item.type_a;
	assign req.shape_type_b = drv_item.type_b;
	assign req.sim_frame    = drv_item.frame;
	assign rsp.ready        = sink_ready;

	pair_agent_hash_cache uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Shadow of the cache contents and register
	logic [ID_W-1:0]    slot_first  [MAX_SLOTS];
	logic [ID_W-1:0]    slot_second [MAX_SLOTS];
	logic [FRAME_W-1:0] slot_frame  [MAX_SLOTS];
	logic [ID_W-1:0]    spare_first;
	logic [ID_W-1:0]    spare_second;
	logic [FRAME_W-1:0] spare_frame;
	logic [CSIZE_W-1:0] cfg_table_size;

	pair_req_t pending_reqs  [$];
	pair_rsp_t expected_rsps [$];

	// Random object pool, refreshed per phase so pairs repeat and hit
	logic [ID_W-1:0]    pool_id   [POOL_N];
	logic [KEY_W-1:0]   pool_key  [POOL_N];
	logic [TYPE_W-1:0]  pool_type [POOL_N];
	logic [FRAME_W-1:0] frame_now;

	int  pushed_cnt   = 0;
	int  accepted_cnt = 0;
	int  result_cnt   = 0;
	int  mismatch_cnt = 0;
	int  hit_cnt      = 0;
	int  claim_cnt    = 0;
	int  spare_cnt    = 0;
	int  inval_cnt    = 0;
	int  cfg_writes   = 0;
	int  quiet_cycles = 0;
	int  hold_left    = 0;
	bit  hold_started = 1'b0;
	bit  hold_request = 1'b0;
	bit  steady_run   = 1'b0;
	bit  req_taken    = 1'b0;

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatch_cnt < PRINT_CAP) begin
			$display("mismatch at result %0d: %s got %0h expected %0h",
				result_cnt, what, got, want);
		end
		mismatch_cnt++;
	endtask

	function automatic void clear_store();
		for (int i = 0; i < MAX_SLOTS; i++) begin
			slot_first[i]  = '0;
			slot_second[i] = '0;
			slot_frame[i]  = '0;
		end
		spare_first  = '0;
		spare_second = '0;
		spare_frame  = '0;
	endfunction

	function automatic int slots_in_use();
		if (cfg_table_size == 0)
			return 1;
		if (cfg_table_size > MAX_SLOTS)
			return MAX_SLOTS;
		return int'(cfg_table_size);
	endfunction

	// Apply one accepted request to the shadow and give its result
	function automatic pair_rsp_t resolve_request(input pair_req_t it);
		pair_rsp_t          r;
		logic [ID_W-1:0]    first;
		logic [ID_W-1:0]    second;
		logic [31:0]        n;
		logic [31:0]        slot_no;
		logic [FRAME_W-1:0] age;
		r = '0;
		n = slots_in_use();
		if (it.operation == OP_INVAL) begin
			for (int i = 0; i < n; i++) begin
				if (slot_first[i] == it.a_id)
					slot_first[i] = '0;
				if (slot_second[i] == it.a_id)
					slot_second[i] = '0;
			end
			r.outcome = OUT_INVAL;
			return r;
		end
		if (it.type_a <= it.type_b) begin
			first  = it.a_id;
			second = it.b_id;
		end else begin
			first  = it.b_id;
			second = it.a_id;
		end
		slot_no  = (it.key_a ^ it.key_b) % n;
		r.slot   = slot_no[SLOT_W-1:0];
		r.first  = first;
		r.second = second;
		age      = it.frame - slot_frame[slot_no];
		if (slot_first[slot_no] == first && slot_second[slot_no] == second) begin
			slot_frame[slot_no] = it.frame;
			r.outcome = OUT_HIT;
		end else if (age > 1) begin
			slot_first[slot_no]  = first;
			slot_second[slot_no] = second;
			slot_frame[slot_no]  = it.frame;
			r.outcome = OUT_CLAIM;
		end else begin
			spare_first  = first;
			spare_second = second;
			spare_frame  = it.frame;
			r.outcome = OUT_SPARE;
		end
		return r;
	endfunction

	function automatic pair_req_t lookup_item(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b,
			input logic [KEY_W-1:0] ka, input logic [KEY_W-1:0] kb,
			input logic [TYPE_W-1:0] ta, input logic [TYPE_W-1:0] tb,
			input logic [FRAME_W-1:0] fr);
		pair_req_t it;
		it = '{OP_LOOKUP, a, b, ka, kb, ta, tb, fr};
		return it;
	endfunction

	function automatic pair_req_t inval_item(input logic [ID_W-1:0] id);
		pair_req_t it;
		it = '{OP_INVAL, id, ID_W'($urandom), $urandom, $urandom,
			TYPE_W'($urandom), TYPE_W'($urandom), $urandom};
		return it;
	endfunction

	function automatic void refresh_pool();
		for (int i = 0; i < POOL_N; i++) begin
			pool_id[i]   = ID_W'($urandom_range(1, 65535));
			pool_key[i]  = $urandom;
			pool_type[i] = TYPE_W'($urandom_range(0, 15));
		end
	endfunction

	// Mostly pairs from the pool at a slowly moving frame, some noise
	function automatic pair_req_t random_item();
		pair_req_t   it;
		int unsigned pick;
		int unsigned i;
		int unsigned j;
		int unsigned step;
		it   = '{1'($urandom_range(0, 1)), ID_W'($urandom), ID_W'($urandom), $urandom,
			$urandom, TYPE_W'($urandom), TYPE_W'($urandom), $urandom};
		pick = $urandom_range(0, 99);
		step = $urandom_range(0, 99);
		if (step < 2)
			frame_now = $urandom;
		else if (step < 40)
			frame_now = frame_now + 1;
		else if (step < 46)
			frame_now = frame_now + $urandom_range(2, 5);
		if (pick < 8) begin
			it.operation = OP_INVAL;
			if (pick < 1)
				it.a_id = '0;
			else if (pick < 6)
				it.a_id = pool_id[$urandom_range(0, POOL_N - 1)];
		end else if (pick >= 20) begin
			i = $urandom_range(0, POOL_N - 1);
			j = $urandom_range(0, POOL_N - 1);
			it = lookup_item(pool_id[i], pool_id[j], pool_key[i], pool_key[j],
				pool_type[i], pool_type[j], frame_now);
		end
		return it;
	endfunction

	task automatic queue_req(input pair_req_t it);
		pending_reqs.push_back(it);
		pushed_cnt++;
	endtask

	// Wait until every request is taken and every result has come back
	task automatic settle();
		while (!(pending_reqs.size() == 0 && accepted_cnt == pushed_cnt
				&& expected_rsps.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write then read back, with the shadow updated at the write edge
	task automatic write_table_size(input logic [CSIZE_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {REG_TABLE_SIZE, 2'b00};
		pwdata  <= {(PDATA_W-CSIZE_W)'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		cfg_table_size = value;
		clear_store();
		cfg_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		psel    <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata[CSIZE_W-1:0] !== cfg_table_size)
			note_mismatch("table size readback", prdata, 32'(cfg_table_size));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_random(input int count, input logic [FRAME_W-1:0] start_frame);
		refresh_pool();
		frame_now = start_frame;
		for (int k = 0; k < count; k++)
			queue_req(random_item());
		settle();
	endtask

	// Request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else if (drv_valid && !req_taken) begin
			drv_valid <= 1'b1;
		end else if (pending_reqs.size() != 0 && (steady_run || $urandom_range(0, 99) >= 21)) begin
			drv_item  <= pending_reqs.pop_front();
			drv_valid <= 1'b1;
		end else begin
			drv_valid <= 1'b0;
		end
	end

	// Result receiver, with one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left  = hold_left - 1;
			sink_ready <= 1'b0;
		end else if (hold_request && !hold_started) begin
			hold_started = 1'b1;
			hold_left    = HOLD_CYCLES;
			sink_ready   <= 1'b0;
		end else begin
			sink_ready <= steady_run || ($urandom_range(0, 99) >= 21);
		end
	end

	// Monitor: predict on each accepted request, check each result
	always @(posedge clk) begin
		pair_rsp_t want;
		pair_rsp_t got;
		req_taken <= drv_valid && (req.ready === 1'b1);
		if (drv_valid && req.ready === 1'b1) begin
			want = resolve_request(drv_item);
			expected_rsps.push_back(want);
			accepted_cnt++;
			case (want.outcome)
				OUT_HIT:   hit_cnt++;
				OUT_CLAIM: claim_cnt++;
				OUT_SPARE: spare_cnt++;
				default:   inval_cnt++;
			endcase
		end
		if (rsp.valid === 1'b1 && sink_ready) begin
			got = '{rsp.outcome, rsp.slot_index, rsp.ordered_first, rsp.ordered_second};
			if (expected_rsps.size() == 0) begin
				note_mismatch("result with nothing expected, outcome", 32'(got.outcome), '0);
			end else begin
				want = expected_rsps.pop_front();
				if (got.outcome !== want.outcome)
					note_mismatch("outcome", 32'(got.outcome), 32'(want.outcome));
				if (got.slot !== want.slot)
					note_mismatch("slot_index", 32'(got.slot), 32'(want.slot));
				if (got.first !== want.first)
					note_mismatch("ordered_first", 32'(got.first), 32'(want.first));
				if (got.second !== want.second)
					note_mismatch("ordered_second", 32'(got.second), 32'(want.second));
			end
			result_cnt++;
		end
	end

	// Watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((drv_valid && req.ready === 1'b1) || (rsp.valid === 1'b1 && sink_ready)
					|| (psel && penable && pready === 1'b1))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		clear_store();
		cfg_table_size = CSIZE_RESET;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(posedge clk);

		// Reset size of one slot: zero pair on empty slot, wrap, extremes
		queue_req(lookup_item('0, '0, '0, '0, '0, '0, '0));
		queue_req(lookup_item(16'hFFFF, 16'h0001, 32'hFFFF_FFFF, '0, 4'hF, 4'h0,
			32'hFFFF_FFFF));
		queue_req(lookup_item(16'h0001, 16'hFFFF, '0, 32'hFFFF_FFFF, 4'h0, 4'hF, '0));
		queue_req(lookup_item(16'h0002, 16'h0003, 32'h1234_5678, 32'h0F0F_0F0F, 4'h5, 4'h5,
			32'h1));
		queue_req(inval_item('0));
		queue_req(inval_item(16'hFFFF));
		// invalidate leaves the frame alone, so this lands in the spare entry
		queue_req(lookup_item(16'h0004, 16'h0005, 32'h0, 32'h0, 4'h3, 4'h7, 32'h1));
		queue_req(lookup_item(16'h0001, 16'h0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 4'h0, 4'hF,
			32'h1));
		settle();

		// Eight slots: claim, swapped hit, collision to spare, later claim, invalidate, extremes
		write_table_size(9'd8);
		queue_req(lookup_item(16'd10, 16'd20, 32'h3, 32'h10, 4'h9, 4'h2, 32'd100));
		queue_req(lookup_item(16'd20, 16'd10, 32'h10, 32'h3, 4'h2, 4'h9, 32'd100));
		queue_req(lookup_item(16'd30, 16'd40, 32'h13, 32'h0, 4'h1, 4'h1, 32'd101));
		queue_req(lookup_item(16'd30, 16'd40, 32'h13, 32'h0, 4'h1, 4'h1, 32'd103));
		queue_req(inval_item(16'd30));
		queue_req(lookup_item(16'd30, 16'd40, 32'h13, 32'h0, 4'h1, 4'h1, 32'd103));
		queue_req(lookup_item(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 4'hF, 4'hF,
			32'h8000_0000));
		queue_req(lookup_item(16'h8000, 16'h7FFF, 32'h8000_0000, 32'h7FFF_FFFF, 4'hA, 4'h5,
			32'h7FFF_FFFF));
		settle();

		// Size zero behaves as one slot
		write_table_size(9'd0);
		queue_req(lookup_item(16'd5, 16'd6, $urandom, $urandom, 4'h2, 4'h1, 32'd50));
		queue_req(inval_item(16'd5));
		run_random(60, 32'd10);

		// Above the slot count saturates; full-size sweeps for invalidate
		write_table_size(9'h1FF);
		run_random(150, 32'hFFFF_FFF0);
		write_table_size(9'd256);
		run_random(150, $urandom);
		write_table_size(9'd257);
		run_random(60, $urandom);

		// A stretch with no idling on either side
		write_table_size(9'd3);
		steady_run = 1'b1;
		run_random(200, $urandom);
		steady_run = 1'b0;

		// Receiver holds off while requests keep coming
		write_table_size(9'd16);
		hold_request = 1'b1;
		run_random(300, $urandom);

		write_table_size(CSIZE_W'($urandom_range(1, 64)));
		run_random(250, $urandom);
		write_table_size(9'd2);
		run_random(130, 32'hFFFF_FFFE);

		$display("covered %0d lookups (%0d hits, %0d claims, %0d spare) and %0d invalidates",
			hit_cnt + claim_cnt + spare_cnt, hit_cnt, claim_cnt, spare_cnt, inval_cnt);
		$display("over %0d table size writes; %0d results checked, %0d mismatches",
			cfg_writes, result_cnt, mismatch_cnt);
		if (mismatch_cnt == 0 && expected_rsps.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
